[sv/plist_pkg.sv]
// Shared types and constants for the positional list block.
package plist_pkg;

    localparam int ACT_W   = 3;
    localparam int POS_W   = 7;
    localparam int ROW_W   = 16;
    localparam int COL_W   = 16;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 7;
    localparam int ENTRY_W = ROW_W + COL_W + VAL_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT  = 3'd0,
        ACT_DELETE  = 3'd1,
        ACT_READ    = 3'd2,
        ACT_REPLACE = 3'd3,
        ACT_CLEAR   = 3'd4
    } action_t;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECIDE   = 7'b0000010,
        S_SHIFT_UP = 7'b0000100,
        S_SHIFT_DN = 7'b0001000,
        S_DRAIN    = 7'b0010000,
        S_PUT      = 7'b0100000,
        S_FINISH   = 7'b1000000
    } state_t;

    // Commands from the controller to the datapath, valid for one cycle.
    typedef struct packed {
        logic load;
        logic rd_pos;
        logic rd_up;
        logic rd_dn;
        logic capture;
        logic cur_from_count;
        logic cur_from_pos;
        logic set_ok;
        logic put;
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             ins_ok;
        logic             pos_ok;
        logic             cur_gt_pos;
        logic             cur_more_dn;
        logic             out_free;
    } status_t;

endpackage

[sv/plist_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module plist_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/plist_ctrl.sv]
// Controller state machine that sequences each list transaction.
module plist_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  plist_pkg::status_t sts,
    output plist_pkg::cmd_t    cmd
);

    import plist_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_FINISH;
                case (sts.act)
                    ACT_INSERT:
                    begin
                        if (sts.ins_ok)
                        begin
                            cmd.set_ok         = 1'b1;
                            cmd.cur_from_count = 1'b1;
                            state_next         = S_SHIFT_UP;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (sts.pos_ok)
                        begin
                            cmd.set_ok       = 1'b1;
                            cmd.rd_pos       = 1'b1;
                            cmd.capture      = 1'b1;
                            cmd.cur_from_pos = 1'b1;
                            state_next       = S_SHIFT_DN;
                        end
                    end
                    ACT_READ:
                    begin
                        if (sts.pos_ok)
                        begin
                            cmd.set_ok  = 1'b1;
                            cmd.rd_pos  = 1'b1;
                            cmd.capture = 1'b1;
                            state_next  = S_DRAIN;
                        end
                    end
                    ACT_REPLACE:
                    begin
                        if (sts.pos_ok)
                        begin
                            cmd.set_ok = 1'b1;
                            state_next = S_PUT;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        cmd.set_ok  = 1'b1;
                        cmd.cnt_clr = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SHIFT_UP:
            begin
                // Move entries up from the tail until the gap reaches the position.
                if (sts.cur_gt_pos)
                begin
                    cmd.rd_up = 1'b1;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_SHIFT_DN:
            begin
                if (sts.cur_more_dn)
                begin
                    cmd.rd_dn = 1'b1;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_PUT:
            begin
                cmd.put    = 1'b1;
                cmd.cnt_inc = (sts.act == ACT_INSERT);
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/plist_dp.sv]
// Datapath: entry memory, count, shift cursor and the result register.
module plist_dp #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [plist_pkg::ACT_W-1:0]         action,
    input  logic [plist_pkg::POS_W-1:0]         position,
    input  logic [plist_pkg::ROW_W-1:0]         entry_row,
    input  logic [plist_pkg::COL_W-1:0]         entry_col,
    input  logic signed [plist_pkg::VAL_W-1:0]  entry_value,
    input  logic [plist_pkg::CNT_W-1:0]         capacity,
    input  plist_pkg::cmd_t                     cmd,
    output plist_pkg::status_t                  sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                ok,
    output logic [plist_pkg::ROW_W-1:0]         out_row,
    output logic [plist_pkg::COL_W-1:0]         out_col,
    output logic signed [plist_pkg::VAL_W-1:0]  out_value,
    output logic [plist_pkg::CNT_W-1:0]         count,
    output logic                                is_full,
    output logic                                is_empty
);

    import plist_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int WW = (CW > POS_W) ? CW : POS_W;

    logic [ACT_W-1:0]   act_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [ENTRY_W-1:0] item_reg;
    logic [ENTRY_W-1:0] data_reg;
    logic               ok_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      cur_reg;
    logic               wr_pend_reg;
    logic [AW-1:0]      wr_dst_reg;
    logic               cap_pend_reg;
    logic               out_valid_reg;
    logic               out_ok_reg;
    logic [ENTRY_W-1:0] out_data_reg;
    logic [CNT_W-1:0]   out_count_reg;
    logic               out_full_reg;
    logic               out_empty_reg;

    logic [WW-1:0]      count_w;
    logic [WW-1:0]      pos_w;
    logic [WW-1:0]      cur_w;
    logic [WW-1:0]      cap_w;
    logic [WW-1:0]      max_w;
    logic [WW-1:0]      cap_eff;
    logic [AW-1:0]      pos_addr;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    assign count_w  = WW'(count_reg);
    assign pos_w    = WW'(pos_reg);
    assign cur_w    = WW'(cur_reg);
    assign cap_w    = WW'(capacity);
    assign max_w    = WW'(MAX_ENTRIES);
    assign cap_eff  = (cap_w > max_w) ? max_w : cap_w;
    assign pos_addr = pos_w[AW-1:0];

    assign sts.act         = act_reg;
    assign sts.ins_ok      = (count_w < cap_eff) && (pos_w <= count_w) && (count_w < max_w);
    assign sts.pos_ok      = (pos_w < count_w);
    assign sts.cur_gt_pos  = (cur_w > pos_w);
    assign sts.cur_more_dn = ((cur_w + WW'(1)) < count_w);
    assign sts.out_free    = !out_valid_reg || out_ready;

    // A shift step reads one neighbor now and writes it one place over next cycle.
    always_comb
    begin
        ram_re    = cmd.rd_pos || cmd.rd_up || cmd.rd_dn;
        ram_raddr = pos_addr;
        if (cmd.rd_up)
        begin
            ram_raddr = cur_reg[AW-1:0] - AW'(1);
        end
        else if (cmd.rd_dn)
        begin
            ram_raddr = cur_reg[AW-1:0] + AW'(1);
        end
        ram_we    = wr_pend_reg || cmd.put;
        ram_waddr = wr_pend_reg ? wr_dst_reg : pos_addr;
        ram_wdata = wr_pend_reg ? ram_rdata : item_reg;
    end

    plist_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            cap_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg  <= cmd.rd_up || cmd.rd_dn;
            cap_pend_reg <= cmd.capture;
            if (cmd.cnt_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            pos_reg  <= position;
            item_reg <= {entry_row, entry_col, entry_value};
            data_reg <= '0;
            ok_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.set_ok)
            begin
                ok_reg <= 1'b1;
            end
            if (cap_pend_reg)
            begin
                data_reg <= ram_rdata;
            end
        end
        if (cmd.cur_from_count)
        begin
            cur_reg <= count_reg;
        end
        else if (cmd.cur_from_pos)
        begin
            cur_reg <= pos_w[CW-1:0];
        end
        else if (cmd.rd_up)
        begin
            cur_reg <= cur_reg - CW'(1);
        end
        else if (cmd.rd_dn)
        begin
            cur_reg <= cur_reg + CW'(1);
        end
        if (cmd.rd_up || cmd.rd_dn)
        begin
            wr_dst_reg <= cur_reg[AW-1:0];
        end
        if (cmd.emit)
        begin
            out_ok_reg    <= ok_reg;
            out_data_reg  <= data_reg;
            out_count_reg <= count_w[CNT_W-1:0];
            out_full_reg  <= (count_w >= cap_eff);
            out_empty_reg <= (count_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = out_ok_reg;
    assign out_row   = out_data_reg[ENTRY_W-1 -: ROW_W];
    assign out_col   = out_data_reg[VAL_W +: COL_W];
    assign out_value = out_data_reg[VAL_W-1:0];
    assign count     = out_count_reg;
    assign is_full   = out_full_reg;
    assign is_empty  = out_empty_reg;

`ifndef SYNTHESIS
    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_pend_reg && cmd.put))
        else $error("shift write and item write collide");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_w <= max_w)
        else $error("entry count beyond memory depth");
    a_up_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_up |-> (cur_reg != '0) && (cur_w <= count_w))
        else $error("upward shift cursor out of range");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");
    a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("delete did not lower the count");
`endif

endmodule

[sv/positional_list_insert_delete.sv]
// Top level of the positional list: capacity register, controller and datapath.
//
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid/in_ready    action, position, entry_row, entry_col, entry_value
//  result    out        out_valid/out_ready  ok, out_row, out_col, out_value, count, is_full, ...
//  config    in         psel/penable/pready  capacity at byte address 0
//
// One transaction at a time; an insert or a delete takes longer the more entries lie past
// the position, set by the single write port of the entry memory, one entry moved per cycle.
// Reset clears the count and the result valid flag; entries are not cleared and need no pass.
// A waiting result does not block the next input transaction; only the following result waits.
module positional_list_insert_delete #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [plist_pkg::ACT_W-1:0]         action,
    input  logic [plist_pkg::POS_W-1:0]         position,
    input  logic [plist_pkg::ROW_W-1:0]         entry_row,
    input  logic [plist_pkg::COL_W-1:0]         entry_col,
    input  logic signed [plist_pkg::VAL_W-1:0]  entry_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                ok,
    output logic [plist_pkg::ROW_W-1:0]         out_row,
    output logic [plist_pkg::COL_W-1:0]         out_col,
    output logic signed [plist_pkg::VAL_W-1:0]  out_value,
    output logic [plist_pkg::CNT_W-1:0]         count,
    output logic                                is_full,
    output logic                                is_empty,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    import plist_pkg::*;

    localparam logic REG_CAPACITY = 1'b0;

    logic [CNT_W-1:0] cap_reg;
    logic             cap_sel;
    status_t          sts;
    cmd_t             cmd;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[2] == REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CNT_W'(64);
        end
        else if (psel && penable && pwrite && pready && cap_sel)
        begin
            cap_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = cap_sel ? {{(32 - CNT_W){1'b0}}, cap_reg} : 32'd0;

    plist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    plist_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .action      (action),
        .position    (position),
        .entry_row   (entry_row),
        .entry_col   (entry_col),
        .entry_value (entry_value),
        .capacity    (cap_reg),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .count       (count),
        .is_full     (is_full),
        .is_empty    (is_empty)
    );

endmodule

[dv/positional_list_insert_delete_test.sv]
// Self-checking testbench for the positional list: directed table, random phases, APB capacity writes.
module positional_list_insert_delete_test;
    import plist_pkg::*;

    localparam int LIST_DEPTH     = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT    = 100;

    // Action codes the block does not define; it must answer them with ok low.
    localparam logic [ACT_W-1:0] ACT_UNUSED_5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_UNUSED_7 = 3'd7;

    localparam logic [2:0] CAPACITY_ADDR = 3'd0;

    typedef struct {
        logic [ACT_W-1:0]        act;
        logic [POS_W-1:0]        pos;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] val;
    } list_op_t;

    typedef struct {
        logic                    ok;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] val;
        logic [CNT_W-1:0]        cnt;
        logic                    full;
        logic                    empty;
    } list_reply_t;

    typedef struct {
        list_op_t    op;
        bit          known;
        list_reply_t reply;
    } directed_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [ACT_W-1:0]        action = '0;
    logic [POS_W-1:0]        position = '0;
    logic [ROW_W-1:0]        entry_row = '0;
    logic [COL_W-1:0]        entry_col = '0;
    logic signed [VAL_W-1:0] entry_value = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    ok;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic [CNT_W-1:0]        count;
    logic                    is_full;
    logic                    is_empty;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [2:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    // Shadow copy of the list contents, length and capacity register.
    logic [ROW_W-1:0]        list_row [LIST_DEPTH];
    logic [COL_W-1:0]        list_col [LIST_DEPTH];
    logic signed [VAL_W-1:0] list_val [LIST_DEPTH];
    int                      list_len = 0;
    int                      list_cap = 64;

    list_reply_t   pending_replies[$];
    directed_row_t directed_rows[$];
    int            mismatches = 0;
    int            quiet_cycles = 0;
    int            burst_left = 1;
    int            rx_cycle = 0;
    int            rx_hold = 0;

    positional_list_insert_delete #(.MAX_ENTRIES(LIST_DEPTH)) DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    // Applies one operation to the shadow list and returns the reply it must produce.
    function automatic list_reply_t apply_list_op(input list_op_t op);
        list_reply_t r;
        int          lim;
        int          i;
        r = '{default: '0};
        lim = (list_cap > LIST_DEPTH) ? LIST_DEPTH : list_cap;
        case (op.act)
            ACT_INSERT:
                if (list_len < lim && op.pos <= list_len)
                begin
                    for (i = list_len; i > op.pos; i--)
                    begin
                        list_row[i] = list_row[i-1];
                        list_col[i] = list_col[i-1];
                        list_val[i] = list_val[i-1];
                    end
                    list_row[op.pos] = op.row;
                    list_col[op.pos] = op.col;
                    list_val[op.pos] = op.val;
                    list_len++;
                    r.ok = 1'b1;
                end
            ACT_DELETE:
                if (op.pos < list_len)
                begin
                    r.row = list_row[op.pos];
                    r.col = list_col[op.pos];
                    r.val = list_val[op.pos];
                    for (i = op.pos; i + 1 < list_len; i++)
                    begin
                        list_row[i] = list_row[i+1];
                        list_col[i] = list_col[i+1];
                        list_val[i] = list_val[i+1];
                    end
                    list_len--;
                    r.ok = 1'b1;
                end
            ACT_READ:
                if (op.pos < list_len)
                begin
                    r.row = list_row[op.pos];
                    r.col = list_col[op.pos];
                    r.val = list_val[op.pos];
                    r.ok = 1'b1;
                end
            ACT_REPLACE:
                if (op.pos < list_len)
                begin
                    list_row[op.pos] = op.row;
                    list_col[op.pos] = op.col;
                    list_val[op.pos] = op.val;
                    r.ok = 1'b1;
                end
            ACT_CLEAR:
            begin
                list_len = 0;
                r.ok = 1'b1;
            end
            default:
                ;
        endcase
        r.cnt = list_len[CNT_W-1:0];
        r.full = (list_len >= lim);
        r.empty = (list_len == 0);
        return r;
    endfunction

    function automatic directed_row_t row_op(input logic [ACT_W-1:0] a,
                                             input logic [POS_W-1:0] p,
                                             input logic [ROW_W-1:0] r,
                                             input logic [COL_W-1:0] c,
                                             input logic [VAL_W-1:0] v);
        directed_row_t d;
        d.op = '{act: a, pos: p, row: r, col: c, val: v};
        d.known = 1'b0;
        d.reply = '{default: '0};
        return d;
    endfunction

    // Attaches a hand-written reply; such rows never return list data.
    function automatic directed_row_t row_known(input directed_row_t d, input logic k,
                                                input logic [CNT_W-1:0] n,
                                                input logic f, input logic e);
        d.known = 1'b1;
        d.reply = '{ok: k, row: '0, col: '0, val: '0, cnt: n, full: f, empty: e};
        return d;
    endfunction

    function automatic list_op_t random_op(input int ins_pct, input int del_pct,
                                           input int clr_pct);
        list_op_t op;
        int       roll;
        int       top;
        roll = $urandom_range(0, 99);
        if (roll < clr_pct)
            op.act = ACT_CLEAR;
        else if (roll < clr_pct + 2)
            op.act = ACT_W'($urandom_range(ACT_UNUSED_5, ACT_UNUSED_7));
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                op.act = ACT_INSERT;
            else if (roll < ins_pct + del_pct)
                op.act = ACT_DELETE;
            else if (roll[0])
                op.act = ACT_READ;
            else
                op.act = ACT_REPLACE;
        end
        top = (op.act == ACT_INSERT) ? list_len : list_len - 1;
        if (top < 0)
            top = 0;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            op.pos = POS_W'($urandom_range(0, 127));
        else if (roll < 20)
            op.pos = '0;
        else if (roll < 30)
            op.pos = POS_W'(top);
        else
            op.pos = POS_W'($urandom_range(0, top));
        op.row = ROW_W'($urandom);
        op.col = COL_W'($urandom);
        op.val = $urandom;
        return op;
    endfunction

    // Called at a falling edge; returns at a falling edge after the transaction is accepted.
    task automatic issue_op(input list_op_t op, input bit known, input list_reply_t reply);
        list_reply_t want;
        int          gap;
        in_valid <= 1'b1;
        action <= op.act;
        position <= op.pos;
        entry_row <= op.row;
        entry_col <= op.col;
        entry_value <= op.val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = apply_list_op(op);
        pending_replies.push_back(known ? reply : want);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAPACITY_ADDR;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        list_cap = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== value)
            note_mismatch("capacity readback", prdata, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input int cap, input int n, input int ins_pct,
                             input int del_pct, input int clr_pct);
        list_reply_t none;
        none = '{default: '0};
        write_capacity(cap);
        repeat (n)
            issue_op(random_op(ins_pct, del_pct, clr_pct), 1'b0, none);
        drain_replies();
    endtask

    // The receiver cycles through steady, coin-flip and long-stall behavior.
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 256) % 3)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            default:
                if (rx_hold > 0)
                begin
                    out_ready <= 1'b0;
                    rx_hold <= rx_hold - 1;
                end
                else
                begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        rx_hold <= $urandom_range(1, 15);
                end
        endcase
    end

    always @(posedge clk)
    begin
        list_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
                note_mismatch("result with no transaction pending", 0, 0);
            else
            begin
                want = pending_replies.pop_front();
                if (ok !== want.ok)
                    note_mismatch("ok", 32'(ok), 32'(want.ok));
                if (out_row !== want.row)
                    note_mismatch("out_row", 32'(out_row), 32'(want.row));
                if (out_col !== want.col)
                    note_mismatch("out_col", 32'(out_col), 32'(want.col));
                if (out_value !== want.val)
                    note_mismatch("out_value", out_value, want.val);
                if (count !== want.cnt)
                    note_mismatch("count", 32'(count), 32'(want.cnt));
                if (is_full !== want.full)
                    note_mismatch("is_full", 32'(is_full), 32'(want.full));
                if (is_empty !== want.empty)
                    note_mismatch("is_empty", 32'(is_empty), 32'(want.empty));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        directed_rows.push_back(row_known(row_op(ACT_READ, 0, 0, 0, 0), 0, 0, 0, 1));
        directed_rows.push_back(row_known(row_op(ACT_DELETE, 0, 0, 0, 0), 0, 0, 0, 1));
        directed_rows.push_back(row_known(row_op(ACT_REPLACE, 0, 16'h1, 16'h1, 1),
                                          0, 0, 0, 1));
        directed_rows.push_back(row_known(row_op(ACT_INSERT, 1, 16'h2, 16'h2, 2), 0, 0, 0, 1));
        directed_rows.push_back(row_known(row_op(ACT_INSERT, 127, 16'h3, 16'h3, 3),
                                          0, 0, 0, 1));
        directed_rows.push_back(row_known(row_op(ACT_INSERT, 0, 16'hFFFF, 16'hFFFF,
                                                 32'h7FFF_FFFF), 1, 1, 0, 0));
        directed_rows.push_back(row_known(row_op(ACT_INSERT, 0, 16'h0, 16'h0,
                                                 32'h8000_0000), 1, 2, 0, 0));
        directed_rows.push_back(row_known(row_op(ACT_INSERT, 2, 16'h1234, 16'hABCD,
                                                 32'hFFFF_FFFF), 1, 3, 0, 0));
        directed_rows.push_back(row_known(row_op(ACT_INSERT, 1, 16'h0001, 16'h8000,
                                                 32'h0000_0001), 1, 4, 0, 0));
        directed_rows.push_back(row_op(ACT_READ, 0, 0, 0, 0));
        directed_rows.push_back(row_op(ACT_READ, 3, 0, 0, 0));
        directed_rows.push_back(row_known(row_op(ACT_READ, 4, 0, 0, 0), 0, 4, 0, 0));
        directed_rows.push_back(row_known(row_op(ACT_REPLACE, 2, 16'hAAAA, 16'h5555,
                                                 32'h5555_5555), 1, 4, 0, 0));
        directed_rows.push_back(row_known(row_op(ACT_REPLACE, 4, 16'h7, 16'h7, 7),
                                          0, 4, 0, 0));
        directed_rows.push_back(row_op(ACT_READ, 2, 0, 0, 0));
        directed_rows.push_back(row_op(ACT_DELETE, 1, 0, 0, 0));
        directed_rows.push_back(row_known(row_op(ACT_DELETE, 127, 0, 0, 0), 0, 3, 0, 0));
        directed_rows.push_back(row_known(row_op(ACT_UNUSED_5, 0, 16'h9, 16'h9, 9),
                                          0, 3, 0, 0));
        directed_rows.push_back(row_known(row_op(ACT_UNUSED_6, 1, 0, 0, 0), 0, 3, 0, 0));
        directed_rows.push_back(row_known(row_op(ACT_UNUSED_7, 2, 0, 0, 0), 0, 3, 0, 0));
        directed_rows.push_back(row_op(ACT_DELETE, 2, 0, 0, 0));
        directed_rows.push_back(row_op(ACT_READ, 1, 0, 0, 0));
        directed_rows.push_back(row_known(row_op(ACT_CLEAR, 0, 0, 0, 0), 1, 0, 0, 1));
        directed_rows.push_back(row_known(row_op(ACT_READ, 0, 0, 0, 0), 0, 0, 0, 1));
        directed_rows.push_back(row_known(row_op(ACT_INSERT, 0, 16'h7FFF, 16'h0001, 0),
                                          1, 1, 0, 0));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
            issue_op(directed_rows[k].op, directed_rows[k].known, directed_rows[k].reply);
        drain_replies();

        // Fill to full, then shrink the capacity under a populated list.
        run_phase(64, 120, 85, 5, 0);
        run_phase(5, 60, 40, 30, 0);
        run_phase(0, 40, 40, 30, 0);
        run_phase(127, 90, 10, 70, 0);
        run_phase(1, 60, 35, 30, 3);
        run_phase(2, 60, 35, 30, 3);
        run_phase(127, 100, 70, 15, 1);
        run_phase($urandom_range(1, 64), 70, 40, 30, 2);
        run_phase(64, 50, 20, 50, 2);

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
